@@ rtl/core/sm3c_pkg.sv @@
// sm3c_pkg: shared types, constants and round helper functions for the sm3 compression core
// depends on nothing; imported by sm3c_ctrl, sm3c_datapath and sm3_compression
package sm3c_pkg;

    // command codes of an input beat
    localparam logic CMD_LOAD_CV = 1'b0;
    localparam logic CMD_MSG     = 1'b1;

    // round constants, high constant pre-rotated for round sixteen
    localparam logic [31:0] T_LOW      = 32'h79cc4519;
    localparam logic [31:0] T_HIGH     = 32'h7a879d8a;
    localparam logic [31:0] T_HIGH_R16 = {T_HIGH[15:0], T_HIGH[31:16]};

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_WORDS  = 16;
    localparam int unsigned NUM_CV     = 8;

    typedef struct packed {
        logic        command;
        logic [2:0]  word_index;
        logic [31:0] word_value;
    } t_in;

    typedef struct packed {
        logic [2:0]  digest_index;
        logic [31:0] digest_word;
        logic        last_word;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic       load_cv;
        logic       load_msg;
        logic       start_comp;
        logic       round;
        logic       early;
        logic       t_switch;
        logic       finalize;
        logic       emit;
        logic [2:0] emit_idx;
    } t_ctl;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 9) ^ rotl32(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 15) ^ rotl32(x, 23);
    endfunction

endpackage

@@ rtl/core/sm3c_ctrl.sv @@
// sm3c_ctrl: sequencer for word loading, the 64 rounds, the chaining update and digest output
// depends on sm3c_pkg
module sm3c_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_command,
    output logic          o_busy,
    output sm3c_pkg::t_ctl o_ctl
);
    import sm3c_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam logic [3:0] LAST_WORD  = 4'(NUM_WORDS - 1);
    localparam logic [5:0] LAST_ROUND = 6'(NUM_ROUNDS - 1);
    localparam logic [5:0] T_SW_ROUND = 6'd15;
    localparam logic [2:0] LAST_CV    = 3'(NUM_CV - 1);

    logic [1:0] r_state, n_state;
    logic [3:0] r_word_cnt, n_word_cnt;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_emit, n_emit;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_word_cnt = r_word_cnt;
        n_rnd      = r_rnd;
        n_emit     = r_emit;
        o_ctl      = '0;
        o_ctl.emit_idx = r_emit;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_LOAD_CV) begin
                        o_ctl.load_cv = 1'b1;
                    end else begin
                        o_ctl.load_msg = 1'b1;
                        n_word_cnt     = r_word_cnt + 4'd1;
                        if (r_word_cnt == LAST_WORD) begin
                            o_ctl.start_comp = 1'b1;
                            n_rnd            = '0;
                            n_state          = S_ROUND;
                        end
                    end
                end
            end
            S_ROUND: begin
                o_ctl.round    = 1'b1;
                o_ctl.early    = (r_rnd[5:4] == 2'b00);
                o_ctl.t_switch = (r_rnd == T_SW_ROUND);
                n_rnd          = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_ctl.finalize = 1'b1;
                n_emit         = '0;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1;
                n_emit     = r_emit + 3'd1;
                if (r_emit == LAST_CV) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_word_cnt <= '0;
            r_rnd      <= '0;
            r_emit     <= '0;
        end else begin
            r_state    <= n_state;
            r_word_cnt <= n_word_cnt;
            r_rnd      <= n_rnd;
            r_emit     <= n_emit;
        end
    end

endmodule

@@ rtl/core/sm3c_datapath.sv @@
// sm3c_datapath: chaining words, shifting message window, working registers and one round per cycle
// depends on sm3c_pkg; driven by sm3c_ctrl
module sm3c_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sm3c_pkg::t_ctl i_ctl,
    input  sm3c_pkg::t_in  i_in,
    output logic           o_strobe,
    output sm3c_pkg::t_out o_out
);
    import sm3c_pkg::*;

    localparam logic [2:0] LAST_CV = 3'(NUM_CV - 1);

    logic [31:0] r_cv [NUM_CV];
    logic [31:0] r_w  [NUM_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_tj;
    logic        r_strobe;
    t_out        r_out;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

    // round function; window tap k is the model's word (i + k) mod 16
    always_comb begin
        a12 = rotl32(r_a, 12);
        ss1 = rotl32(a12 + r_e + r_tj, 7);
        ss2 = ss1 ^ a12;
        if (i_ctl.early) begin
            ff = r_a ^ r_b ^ r_c;
            gg = r_e ^ r_f ^ r_g;
        end else begin
            ff = (r_a & r_b) | (r_a & r_c) | (r_b & r_c);
            gg = (r_e & r_f) | (~r_e & r_g);
        end
        tt1   = ff + r_d + ss2 + (r_w[0] ^ r_w[4]);
        tt2   = gg + r_h + ss1 + r_w[0];
        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl32(r_w[13], 15))
              ^ rotl32(r_w[3], 7) ^ r_w[10];
    end

    // window shifts toward tap 0 on a message beat and on each round
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_msg || i_ctl.round) begin
            for (int k = 0; k < NUM_WORDS - 1; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[NUM_WORDS - 1] <= i_ctl.load_msg ? i_in.word_value : w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_cv) begin
            r_cv[i_in.word_index] <= i_in.word_value;
        end else if (i_ctl.finalize) begin
            r_cv[0] <= r_cv[0] ^ r_a;
            r_cv[1] <= r_cv[1] ^ r_b;
            r_cv[2] <= r_cv[2] ^ r_c;
            r_cv[3] <= r_cv[3] ^ r_d;
            r_cv[4] <= r_cv[4] ^ r_e;
            r_cv[5] <= r_cv[5] ^ r_f;
            r_cv[6] <= r_cv[6] ^ r_g;
            r_cv[7] <= r_cv[7] ^ r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start_comp) begin
            r_a  <= r_cv[0];
            r_b  <= r_cv[1];
            r_c  <= r_cv[2];
            r_d  <= r_cv[3];
            r_e  <= r_cv[4];
            r_f  <= r_cv[5];
            r_g  <= r_cv[6];
            r_h  <= r_cv[7];
            r_tj <= T_LOW;
        end else if (i_ctl.round) begin
            r_d  <= r_c;
            r_c  <= rotl32(r_b, 9);
            r_b  <= r_a;
            r_a  <= tt1;
            r_h  <= r_g;
            r_g  <= rotl32(r_f, 19);
            r_f  <= r_e;
            r_e  <= perm0(tt2);
            // constant rotates by one per round, switches after round fifteen
            r_tj <= i_ctl.t_switch ? T_HIGH_R16 : {r_tj[30:0], r_tj[31]};
        end
    end

    // registered result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out.digest_index <= i_ctl.emit_idx;
            r_out.digest_word  <= r_cv[i_ctl.emit_idx];
            r_out.last_word    <= (i_ctl.emit_idx == LAST_CV);
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

@@ rtl/core/sm3_compression.sv @@
// sm3_compression: top level of the sm3 compression engine
// depends on sm3c_pkg, sm3c_ctrl and sm3c_datapath
//
//   channel   handshake             payload           direction
//   input     start / busy          i_in   (t_in)     in
//   result    o_strobe (one cycle)  o_out  (t_out)    out
//
// a load or message beat is taken whenever start is high while idle
// the sixteenth message beat starts 64 rounds at one round per cycle in the shared
// round datapath, then the chaining update and eight result beats; busy stays high
// through all of them, so no new beat is taken until the last result beat is issued
// synchronous active-low reset clears the sequencer, word count and result strobe;
// chaining words and message window hold nothing meaningful until written
// results come out one per cycle and the receiver cannot stall them
module sm3_compression (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sm3c_pkg::t_in  i_in,
    output logic           busy,
    output logic           o_strobe,
    output sm3c_pkg::t_out o_out
);
    import sm3c_pkg::*;

    t_ctl ctl;

    // sequencer: word count, round count and output count
    sm3c_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_in.command),
        .o_busy    (busy),
        .o_ctl     (ctl)
    );

    // storage and round logic
    sm3c_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

@@ bench/sm3_compression_tb.sv @@
// sm3_compression_tb: self-checking bench for the sm3 compression engine
// depends on sm3c_pkg and sm3_compression; holds its own digest tracker class
// and the tasks that drive command beats with random gaps

module sm3_compression_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sm3c_pkg::*;

    // cycles with no beat moving on either side before the run is called hung
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    // random beats after the directed part, rounded up to a whole block
    localparam int unsigned RANDOM_BEATS   = 195;
    // rounds, chaining update and eight result beats after the last word
    localparam int unsigned DRAIN_CYCLES   = 80;

    // tracks chaining words and message window, predicts each digest beat
    class digest_tracker;
        logic [31:0] chain [8];
        logic [31:0] window [16];
        int unsigned held;
        t_out        pending_digest [$];
        int unsigned errors;
        int unsigned loads;
        int unsigned msg_words;
        int unsigned blocks;
        int unsigned checked;

        function new();
            held      = 0;
            errors    = 0;
            loads     = 0;
            msg_words = 0;
            blocks    = 0;
            checked   = 0;
        endfunction

        function logic [31:0] rotate_left(logic [31:0] x, int unsigned n);
            int unsigned s;
            s = n % 32;
            if (s == 0) begin
                return x;
            end
            return (x << s) | (x >> (32 - s));
        endfunction

        function logic [31:0] mix_p0(logic [31:0] x);
            return x ^ rotate_left(x, 9) ^ rotate_left(x, 17);
        endfunction

        function logic [31:0] mix_p1(logic [31:0] x);
            return x ^ rotate_left(x, 15) ^ rotate_left(x, 23);
        endfunction

        // 64 rounds over the window, expanding it in place, then fold into chain
        function void run_rounds();
            logic [31:0] v [8];
            logic [31:0] tk, a12, ss1, ss2, ff, gg, tt1, tt2;
            int unsigned j;
            for (int k = 0; k < 8; k++) begin
                v[k] = chain[k];
            end
            for (int unsigned rnd = 0; rnd < 64; rnd++) begin
                j   = rnd % 16;
                tk  = (rnd < 16) ? T_LOW : T_HIGH;
                a12 = rotate_left(v[0], 12);
                ss1 = rotate_left(a12 + v[4] + rotate_left(tk, rnd % 32), 7);
                ss2 = ss1 ^ a12;
                if (rnd < 16) begin
                    ff = v[0] ^ v[1] ^ v[2];
                    gg = v[4] ^ v[5] ^ v[6];
                end else begin
                    ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                    gg = (v[4] & v[5]) | (~v[4] & v[6]);
                end
                tt1 = ff + v[3] + ss2 + (window[j] ^ window[(j + 4) % 16]);
                tt2 = gg + v[7] + ss1 + window[j];
                window[j] = mix_p1(window[j] ^ window[(j + 7) % 16]
                                   ^ rotate_left(window[(j + 13) % 16], 15))
                          ^ rotate_left(window[(j + 3) % 16], 7) ^ window[(j + 10) % 16];
                v[3] = v[2];
                v[2] = rotate_left(v[1], 9);
                v[1] = v[0];
                v[0] = tt1;
                v[7] = v[6];
                v[6] = rotate_left(v[5], 19);
                v[5] = v[4];
                v[4] = mix_p0(tt2);
            end
            for (int k = 0; k < 8; k++) begin
                chain[k] = chain[k] ^ v[k];
            end
        endfunction

        // an accepted command beat
        function void take_beat(t_in beat);
            t_out d;
            if (beat.command == CMD_LOAD_CV) begin
                chain[beat.word_index] = beat.word_value;
                loads++;
                return;
            end
            window[held] = beat.word_value;
            held = (held + 1) % 16;
            msg_words++;
            if (held != 0) begin
                return;
            end
            run_rounds();
            blocks++;
            for (int k = 0; k < 8; k++) begin
                d.digest_index = k[2:0];
                d.digest_word  = chain[k];
                d.last_word    = (k == 7);
                pending_digest.push_back(d);
            end
        endfunction

        // a result beat seen on the strobe
        function void check_digest(t_out got);
            t_out want;
            if (pending_digest.size() == 0) begin
                errors++;
                $display("%0t: digest beat with nothing expected: index %0d word %h last %b",
                         $time, got.digest_index, got.digest_word, got.last_word);
                return;
            end
            want = pending_digest.pop_front();
            checked++;
            if (got.digest_index !== want.digest_index) begin
                errors++;
                $display("%0t: digest_index expected %0d actual %0d",
                         $time, want.digest_index, got.digest_index);
            end
            if (got.digest_word !== want.digest_word) begin
                errors++;
                $display("%0t: digest_word[%0d] expected %h actual %h",
                         $time, want.digest_index, want.digest_word, got.digest_word);
            end
            if (got.last_word !== want.last_word) begin
                errors++;
                $display("%0t: last_word[%0d] expected %b actual %b",
                         $time, want.digest_index, want.last_word, got.last_word);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_in  i_in;
    logic busy;
    logic o_strobe;
    t_out o_out;

    digest_tracker tracker = new();

    int unsigned gap_pct;
    int unsigned quiet_cycles;
    int unsigned beats_in;

    sm3_compression dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // monitor: every read here sees the values from before the edge, so a beat
    // is taken exactly when start was high and busy low going into this edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                tracker.take_beat(i_in);
                beats_in++;
                quiet_cycles = 0;
            end else if (o_strobe === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            // results cannot be held off, so every strobe is a beat
            if (o_strobe === 1'b1) begin
                tracker.check_digest(o_out);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d digest beats outstanding",
                         $time, quiet_cycles, tracker.pending_digest.size());
                $display("sm3_compression verification failed");
                $finish;
            end
        end
    end

    // value picker that hits all-zero and all-one words often
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // present one command beat and hold it until the block takes it;
    // start drops for idle gaps before it, each gap added with gap_pct chance
    task automatic send_beat(input t_in beat);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= beat;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) begin
                break;
            end
        end
    endtask

    task automatic send_load(input logic [2:0] idx, input logic [31:0] value);
        t_in beat;
        beat.command    = CMD_LOAD_CV;
        beat.word_index = idx;
        beat.word_value = value;
        send_beat(beat);
    endtask

    task automatic send_msg(input logic [31:0] value);
        t_in beat;
        beat.command    = CMD_MSG;
        beat.word_index = 3'($urandom_range(7));
        beat.word_value = value;
        send_beat(beat);
    endtask

    // standard initial value, loaded in reverse index order
    logic [31:0] init_chain [8] = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                                    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    initial begin
        int unsigned n;
        int unsigned msg_pos;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_in         = '0;
        gap_pct      = 32;
        quiet_cycles = 0;
        beats_in     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every chaining word written before any compression
        for (int k = 7; k >= 0; k--) begin
            send_load(k[2:0], init_chain[k]);
        end
        // the padded three-byte message block, a known answer for the standard
        send_msg(32'h61626380);
        for (int k = 1; k < 15; k++) begin
            send_msg(32'h0000_0000);
        end
        send_msg(32'h0000_0018);
        // all-ones chaining word mixed in ahead of the next block
        send_load(3'd7, 32'hffff_ffff);

        // random blocks with loads sprinkled between message words,
        // plus a stretch where the sender never pauses
        n       = 0;
        msg_pos = 0;
        while (n < RANDOM_BEATS || msg_pos != 0) begin
            gap_pct = (n >= 80 && n < 140) ? 0 : 32;
            if ($urandom_range(99) < 15) begin
                send_load(3'($urandom_range(7)), pick_word());
            end else begin
                send_msg(pick_word());
                msg_pos = (msg_pos + 1) % 16;
            end
            n++;
        end
        start <= 1'b0;

        // drain: the watchdog bounds this wait
        while (tracker.pending_digest.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.pending_digest.size() != 0) begin
            tracker.errors++;
            $display("%0t: %0d digest beats never came out",
                     $time, tracker.pending_digest.size());
        end

        $display("covered %0d command beats: %0d chaining loads, %0d message words",
                 beats_in, tracker.loads, tracker.msg_words);
        $display("%0d blocks compressed, %0d digest beats checked, %0d mismatches",
                 tracker.blocks, tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("sm3_compression verification clean");
        end else begin
            $display("sm3_compression verification failed");
        end
        $finish;
    end

endmodule
